@@ hdl/hpd_pkg.sv @@
// shared constants, command codes and types for the prefix-code decoder
package hpd_pkg;

  // field widths of the request and result channels
  localparam int CMD_W  = 2;
  localparam int SYM_W  = 8;
  localparam int CODE_W = 16;
  localparam int LEN_W  = 5;

  // code table geometry
  localparam int MAX_CODE_LEN = 16;
  localparam int SYMBOL_COUNT = 256;
  localparam int LIMIT        = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  // a code of length l with bits c is keyed as (1 << l) | c, so the marker bit gives the length
  localparam int KEY_W     = LIMIT + 1;
  localparam int LUT_DEPTH = 1 << KEY_W;
  localparam int SYM_AW    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LUT_W     = SYM_AW + 1;

  localparam logic [KEY_W-1:0]  KEY_EMPTY = KEY_W'(1);
  localparam logic [SYM_AW-1:0] SYM_LAST  = SYM_AW'(SYMBOL_COUNT - 1);

  // request queue between front and back, depth is a power of two
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DECODE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_END    = 2'd3;

  // classified request as it sits in the queue
  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [SYM_AW-1:0] sym;
    logic [KEY_W-1:0]  key;
    logic              live;
    logic              coded_bit;
  } hpd_item_t;

  // back end status seen by the front end
  typedef struct packed {
    logic pop;
    logic busy;
  } hpd_back_status_t;

  // lookup entry: lowest symbol owning a key
  typedef struct packed {
    logic              valid;
    logic [SYM_AW-1:0] sym;
  } hpd_lut_ent_t;

endpackage

@@ hdl/huffman_prefix_decoder.sv @@
// top level of the prefix-code decoder: front end, request queue and back end
// decode bit: one request per cycle while results drain; path: queue, issue stage, result buffer
// end of stream clears the accumulator; load: a symbol table sweep when the symbol owned its key
// clear: one symbol table entry per cycle through the lookup ram write port
// the code lookup ram is read once per bit, and its registered read sets the per-bit loop
// after rst_n all 2^(LIMIT+1) (131072) lookup ram entries are cleared with in_stall held high
module huffman_prefix_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [hpd_pkg::CMD_W-1:0]   in_command,
  input  logic [hpd_pkg::SYM_W-1:0]   in_symbol,
  input  logic [hpd_pkg::CODE_W-1:0]  in_code_value,
  input  logic [hpd_pkg::LEN_W-1:0]   in_code_length,
  input  logic                        in_coded_bit,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hpd_pkg::SYM_W-1:0]   out_decoded_symbol,
  output logic                        out_overflow_error
);

  // queue head and back end status
  logic                       q_valid;
  hpd_pkg::hpd_item_t         q_item;
  hpd_pkg::hpd_back_status_t  bst;

  // front end turns each request into a queue entry: the load key is built here
  // as a marker bit above the masked code, and loads that must be ignored are dropped
  hpd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_symbol      (in_symbol),
    .in_code_value  (in_code_value),
    .in_code_length (in_code_length),
    .in_coded_bit   (in_coded_bit),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .bst            (bst)
  );

  // back end keeps the symbol table (key per symbol) and a lookup ram indexed by key
  // that holds the lowest symbol owning each key; decode bits look up the accumulator
  // key through the registered ram read and the result lands in a two entry buffer, so a stalled result
  // side does not stop requests until the buffer and queue fill
  hpd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .bst                (bst),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_decoded_symbol (out_decoded_symbol),
    .out_overflow_error (out_overflow_error)
  );

endmodule

@@ hdl/hpd_ram.sv @@
// generic single write port ram with registered read
module hpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/hpd_front.sv @@
// front end: takes requests, classifies them and queues them for the back end
module hpd_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [hpd_pkg::CMD_W-1:0]        in_command,
  input  logic [hpd_pkg::SYM_W-1:0]        in_symbol,
  input  logic [hpd_pkg::CODE_W-1:0]       in_code_value,
  input  logic [hpd_pkg::LEN_W-1:0]        in_code_length,
  input  logic                             in_coded_bit,
  output logic                             q_valid,
  output hpd_pkg::hpd_item_t               q_item,
  input  hpd_pkg::hpd_back_status_t        bst
);

  function automatic logic [hpd_pkg::KEY_W-1:0] make_key(
    input logic [hpd_pkg::CODE_W-1:0] value,
    input logic [hpd_pkg::LEN_W-1:0]  len
  );
    logic [hpd_pkg::KEY_W-1:0] k;
    logic [hpd_pkg::CODE_W:0]  vx;
    vx = {1'b0, value};
    for (int i = 0; i < hpd_pkg::KEY_W; i++) begin
      k[i] = (int'(len) == i) || ((i < int'(len)) && vx[i]);
    end
    return k;
  endfunction

  hpd_pkg::hpd_item_t     q_mem_r [hpd_pkg::QDEPTH];
  logic [hpd_pkg::QAW-1:0] wptr_r, wptr_nxt;
  logic [hpd_pkg::QAW-1:0] rptr_r, rptr_nxt;
  logic [hpd_pkg::QAW:0]   cnt_r, cnt_nxt;
  hpd_pkg::hpd_item_t     item;
  logic                   accept, drop, push, pop;

  // loads with a too long code or a symbol beyond the table leave no trace
  assign drop = (in_command == hpd_pkg::CMD_LOAD) &&
                ((int'(in_code_length) > hpd_pkg::LIMIT) ||
                 (int'(in_symbol) >= hpd_pkg::SYMBOL_COUNT));

  assign in_stall = (cnt_r == (hpd_pkg::QAW+1)'(hpd_pkg::QDEPTH)) || bst.busy;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && !drop;
  assign pop      = bst.pop;

  always_comb begin
    item.op        = in_command;
    item.sym       = in_symbol[hpd_pkg::SYM_AW-1:0];
    item.key       = make_key(in_code_value, in_code_length);
    item.live      = (in_code_length != '0);
    item.coded_bit = in_coded_bit;
  end

  assign q_valid = (cnt_r != '0);
  assign q_item  = q_mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + (hpd_pkg::QAW+1)'(push) - (hpd_pkg::QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

@@ hdl/hpd_back.sv @@
// back end: bit decoder, table maintenance sequencer and result buffer
module hpd_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  hpd_pkg::hpd_item_t         q_item,
  output hpd_pkg::hpd_back_status_t  bst,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [hpd_pkg::SYM_W-1:0]  out_decoded_symbol,
  output logic                       out_overflow_error
);

  localparam logic [3:0] ST_INIT     = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_CLR      = 4'd2;
  localparam logic [3:0] ST_CLR_LAST = 4'd3;
  localparam logic [3:0] ST_LD_OLD   = 4'd4;
  localparam logic [3:0] ST_LD_CHK   = 4'd5;
  localparam logic [3:0] ST_SCAN     = 4'd6;
  localparam logic [3:0] ST_SCAN_LST = 4'd7;
  localparam logic [3:0] ST_INS_RD   = 4'd8;
  localparam logic [3:0] ST_INS      = 4'd9;

  typedef struct packed {
    logic [hpd_pkg::SYM_W-1:0] sym;
    logic                      err;
  } res_t;

  logic [3:0]                        state_r, state_nxt;
  logic [hpd_pkg::SYM_AW-1:0]        cnt_r, cnt_nxt;
  logic [hpd_pkg::KEY_W-1:0]         init_cnt_r, init_cnt_nxt;
  logic                              sw_v_r, sw_v_nxt;
  logic [hpd_pkg::SYM_AW-1:0]        sw_idx_r, sw_idx_nxt;
  logic                              found_r, found_nxt;
  logic [hpd_pkg::SYM_AW-1:0]        found_sym_r, found_sym_nxt;
  logic [hpd_pkg::SYM_AW-1:0]        s_r, s_nxt;
  logic [hpd_pkg::KEY_W-1:0]         new_key_r, new_key_nxt;
  logic                              new_live_r, new_live_nxt;
  logic [hpd_pkg::KEY_W-1:0]         old_key_r, old_key_nxt;
  logic [hpd_pkg::KEY_W-1:0]         acc_r, acc_nxt;
  logic                              p1_valid_r, p1_valid_nxt;
  logic [hpd_pkg::KEY_W-1:0]         p1_key_r, p1_key_nxt;
  logic [hpd_pkg::SYMBOL_COUNT-1:0]  sym_valid_r, sym_valid_nxt;

  res_t                              ob_mem_r [2];
  logic                              ob_wp_r, ob_rp_r;
  logic [1:0]                        ob_cnt_r, ob_cnt_nxt;
  logic                              ob_push, ob_pop;
  res_t                              ob_in;

  logic                              lut_we;
  logic [hpd_pkg::KEY_W-1:0]         lut_waddr, lut_raddr;
  hpd_pkg::hpd_lut_ent_t             lut_wdata, lut_rd;
  logic [hpd_pkg::LUT_W-1:0]         lut_rdata;

  logic                              sym_we;
  logic [hpd_pkg::SYM_AW-1:0]        sym_raddr;
  logic [hpd_pkg::KEY_W-1:0]         sym_rdata;

  logic                              idle, room, hit, err, term;
  logic                              dec_go, end_go, ld_go, clr_go;
  logic [hpd_pkg::KEY_W-1:0]         acc_eff, key_ext;
  logic [hpd_pkg::SYM_AW-1:0]        vld_idx;
  logic                              vld_bit, sw_last, cand;

  hpd_ram #(.WIDTH(hpd_pkg::LUT_W), .DEPTH(hpd_pkg::LUT_DEPTH)) u_lut (
    .clk   (clk),
    .we    (lut_we),
    .waddr (lut_waddr),
    .wdata (lut_wdata),
    .raddr (lut_raddr),
    .rdata (lut_rdata)
  );

  hpd_ram #(.WIDTH(hpd_pkg::KEY_W), .DEPTH(hpd_pkg::SYMBOL_COUNT)) u_sym (
    .clk   (clk),
    .we    (sym_we),
    .waddr (s_r),
    .wdata (new_key_r),
    .raddr (sym_raddr),
    .rdata (sym_rdata)
  );

  assign lut_rd = lut_rdata;

  // result buffer occupancy
  assign ob_pop = (ob_cnt_r != 2'd0) && !out_stall;
  assign room   = (({1'b0, ob_cnt_r} + {2'b0, p1_valid_r}) <= ({2'b0, ob_pop} + 3'd1));

  // decode result stage
  assign hit  = p1_valid_r && lut_rd.valid;
  assign err  = p1_valid_r && !lut_rd.valid && p1_key_r[hpd_pkg::LIMIT];
  assign term = hit || err;

  assign acc_eff = term ? hpd_pkg::KEY_EMPTY : (p1_valid_r ? p1_key_r : acc_r);
  assign key_ext = {acc_eff[hpd_pkg::KEY_W-2:0], q_item.coded_bit};

  assign idle   = (state_r == ST_IDLE);
  assign dec_go = idle && q_valid && (q_item.op == hpd_pkg::CMD_DECODE) && room;
  assign end_go = idle && q_valid && (q_item.op == hpd_pkg::CMD_END);
  assign ld_go  = idle && q_valid && (q_item.op == hpd_pkg::CMD_LOAD) && !p1_valid_r;
  assign clr_go = idle && q_valid && (q_item.op == hpd_pkg::CMD_CLEAR) && !p1_valid_r;

  assign bst.pop  = dec_go || end_go || ld_go || clr_go;
  assign bst.busy = (state_r == ST_INIT);

  // sweep helpers
  assign vld_idx = (state_r == ST_LD_OLD) ? s_r : sw_idx_r;
  assign vld_bit = sym_valid_r[vld_idx];
  assign sw_last = (cnt_r == hpd_pkg::SYM_LAST);
  assign cand    = sw_v_r && vld_bit && (sym_rdata == old_key_r);

  assign sym_raddr = idle ? q_item.sym : cnt_r;
  assign sym_we    = (state_r == ST_LD_OLD);

  always_comb begin
    case (state_r)
      ST_LD_OLD: lut_raddr = sym_rdata;
      ST_INS_RD: lut_raddr = new_key_r;
      default:   lut_raddr = key_ext;
    endcase
  end

  always_comb begin
    lut_we    = 1'b0;
    lut_waddr = new_key_r;
    lut_wdata = '0;
    case (state_r)
      ST_INIT: begin
        lut_we    = 1'b1;
        lut_waddr = init_cnt_r;
      end
      ST_CLR, ST_CLR_LAST: begin
        lut_we    = sw_v_r && vld_bit;
        lut_waddr = sym_rdata;
      end
      ST_SCAN_LST: begin
        lut_we          = 1'b1;
        lut_waddr       = old_key_r;
        lut_wdata.valid = found_r || cand;
        lut_wdata.sym   = found_r ? found_sym_r : sw_idx_r;
      end
      ST_INS: begin
        lut_we          = !lut_rd.valid || (lut_rd.sym > s_r);
        lut_waddr       = new_key_r;
        lut_wdata.valid = 1'b1;
        lut_wdata.sym   = s_r;
      end
      default: begin
        lut_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    init_cnt_nxt  = init_cnt_r;
    found_nxt     = found_r;
    found_sym_nxt = found_sym_r;
    s_nxt         = s_r;
    new_key_nxt   = new_key_r;
    new_live_nxt  = new_live_r;
    old_key_nxt   = old_key_r;
    sym_valid_nxt = sym_valid_r;
    sw_v_nxt      = (state_r == ST_CLR) || (state_r == ST_SCAN);
    sw_idx_nxt    = cnt_r;
    case (state_r)
      ST_INIT: begin
        init_cnt_nxt = init_cnt_r + 1'b1;
        if (&init_cnt_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (ld_go) begin
          s_nxt        = q_item.sym;
          new_key_nxt  = q_item.key;
          new_live_nxt = q_item.live;
          state_nxt    = ST_LD_OLD;
        end else if (clr_go) begin
          cnt_nxt   = '0;
          state_nxt = ST_CLR;
        end
      end
      ST_CLR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (sw_last) begin
          state_nxt = ST_CLR_LAST;
        end
      end
      ST_CLR_LAST: begin
        sym_valid_nxt = '0;
        state_nxt     = ST_IDLE;
      end
      ST_LD_OLD: begin
        old_key_nxt        = sym_rdata;
        sym_valid_nxt[s_r] = new_live_r;
        state_nxt          = vld_bit ? ST_LD_CHK : ST_INS_RD;
      end
      ST_LD_CHK: begin
        if (lut_rd.valid && (lut_rd.sym == s_r)) begin
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_INS_RD;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cand && !found_r) begin
          found_nxt     = 1'b1;
          found_sym_nxt = sw_idx_r;
        end
        if (sw_last) begin
          state_nxt = ST_SCAN_LST;
        end
      end
      ST_SCAN_LST: begin
        state_nxt = ST_INS_RD;
      end
      ST_INS_RD: begin
        state_nxt = new_live_r ? ST_INS : ST_IDLE;
      end
      ST_INS: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // accumulator and decode issue stage
  always_comb begin
    acc_nxt      = (end_go || clr_go) ? hpd_pkg::KEY_EMPTY : acc_eff;
    p1_valid_nxt = dec_go;
    p1_key_nxt   = key_ext;
  end

  // result buffer
  assign ob_push    = term;
  assign ob_in.sym  = hit ? hpd_pkg::SYM_W'(lut_rd.sym) : '0;
  assign ob_in.err  = err;
  assign ob_cnt_nxt = ob_cnt_r + 2'(ob_push) - 2'(ob_pop);

  assign out_valid          = (ob_cnt_r != 2'd0);
  assign out_decoded_symbol = ob_mem_r[ob_rp_r].sym;
  assign out_overflow_error = ob_mem_r[ob_rp_r].err;

  always_ff @(posedge clk) begin
    if (ob_push) begin
      ob_mem_r[ob_wp_r] <= ob_in;
    end
    cnt_r       <= cnt_nxt;
    sw_idx_r    <= sw_idx_nxt;
    found_r     <= found_nxt;
    found_sym_r <= found_sym_nxt;
    s_r         <= s_nxt;
    new_key_r   <= new_key_nxt;
    new_live_r  <= new_live_nxt;
    old_key_r   <= old_key_nxt;
    p1_key_r    <= p1_key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      init_cnt_r  <= '0;
      sw_v_r      <= 1'b0;
      acc_r       <= hpd_pkg::KEY_EMPTY;
      p1_valid_r  <= 1'b0;
      sym_valid_r <= '0;
      ob_wp_r     <= 1'b0;
      ob_rp_r     <= 1'b0;
      ob_cnt_r    <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      init_cnt_r  <= init_cnt_nxt;
      sw_v_r      <= sw_v_nxt;
      acc_r       <= acc_nxt;
      p1_valid_r  <= p1_valid_nxt;
      sym_valid_r <= sym_valid_nxt;
      ob_wp_r     <= ob_push ? ~ob_wp_r : ob_wp_r;
      ob_rp_r     <= ob_pop ? ~ob_rp_r : ob_rp_r;
      ob_cnt_r    <= ob_cnt_nxt;
    end
  end

endmodule

@@ tb/sv/tb_huffman_prefix_decoder.sv @@
// self-checking testbench for the prefix-code decoder: code tables, bit streams, stalls
import hpd_pkg::*;

// one result as the result channel should carry it
typedef struct packed {
  logic [SYM_W-1:0] sym;
  logic             overflow;
} hpd_result_t;

// mirrors the code table and bit accumulator, holds the results still due
class hpd_decode_model;
  logic [LEN_W-1:0]  code_len  [SYMBOL_COUNT];
  logic [CODE_W-1:0] code_bits [SYMBOL_COUNT];
  logic [CODE_W-1:0] shift_bits;
  logic [LEN_W-1:0]  shift_count;
  hpd_result_t       due_results[$];
  int                mismatches;
  int                n_symbols;
  int                n_overflows;

  function new();
    clear_codes();
  endfunction

  function void clear_codes();
    foreach (code_len[s]) begin
      code_len[s]  = '0;
      code_bits[s] = '0;
    end
    shift_bits  = '0;
    shift_count = '0;
  endfunction

  function void flag(string note);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at %0t: %s", $time, note);
  endfunction

  // update the table or accumulator for one accepted request
  function void take_request(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym,
                             logic [CODE_W-1:0] val, logic [LEN_W-1:0] len, logic cbit);
    logic [31:0] mask;
    hpd_result_t r;
    logic        hit;
    case (cmd)
      CMD_CLEAR: clear_codes();
      CMD_LOAD: begin
        if (int'(sym) < SYMBOL_COUNT && int'(len) <= LIMIT) begin
          mask = (int'(len) >= CODE_W) ? 32'hFFFF_FFFF : ((32'd1 << len) - 32'd1);
          code_len[sym]  = len;
          code_bits[sym] = val & mask[CODE_W-1:0];
        end
      end
      CMD_END: begin
        shift_bits  = '0;
        shift_count = '0;
      end
      CMD_DECODE: begin
        shift_bits  = {shift_bits[CODE_W-2:0], cbit};
        shift_count = shift_count + 1'b1;
        r   = '0;
        hit = 1'b0;
        for (int s = 0; s < SYMBOL_COUNT && !hit; s++) begin
          if (code_len[s] != '0 && code_len[s] == shift_count && code_bits[s] == shift_bits) begin
            r.sym = SYM_W'(s);
            hit   = 1'b1;
          end
        end
        if (!hit && int'(shift_count) >= LIMIT) begin
          r.overflow = 1'b1;
          hit        = 1'b1;
        end
        if (hit) begin
          due_results.push_back(r);
          shift_bits  = '0;
          shift_count = '0;
        end
      end
    endcase
  endfunction

  function void check_result(logic [SYM_W-1:0] sym, logic ovf);
    hpd_result_t want;
    if (ovf) n_overflows++;
    else n_symbols++;
    if (due_results.size() == 0) begin
      flag($sformatf("unexpected result, symbol %0d overflow %0b", sym, ovf));
      return;
    end
    want = due_results.pop_front();
    if (sym !== want.sym || ovf !== want.overflow)
      flag($sformatf("symbol expected %0d got %0d, overflow expected %0b got %0b",
                     want.sym, sym, want.overflow, ovf));
  endfunction
endclass

module tb_huffman_prefix_decoder;
  localparam int N_ITEMS   = 1300;   // random requests wanted after the directed part
  localparam int HOLD_CYC  = 400;    // long receiver hold-off
  localparam int WAIT_CYC  = 20000;  // bound on waiting for the last results
  localparam int DRAIN_CYC = 300;    // quiet cycles at the end, covers a clear or a slow load

  logic              clk                = 1'b0;
  logic              rst_n              = 1'b0;
  logic              in_valid           = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  in_command         = CMD_CLEAR;
  logic [SYM_W-1:0]  in_symbol          = '0;
  logic [CODE_W-1:0] in_code_value      = '0;
  logic [LEN_W-1:0]  in_code_length     = '0;
  logic              in_coded_bit       = 1'b0;
  logic              out_valid;
  logic              out_stall          = 1'b0;
  logic [SYM_W-1:0]  out_decoded_symbol;
  logic              out_overflow_error;

  hpd_decode_model decoder = new();

  int n_sent;            // requests that count toward the item total
  int n_loads;
  int n_rejected;        // loads with a code longer than the limit
  int n_holds;
  bit gapless;           // sender offers back to back while set
  bit hold_req;          // asks the receiver for one long hold-off

  // current code set, one entry per leaf of the code tree
  logic [CODE_W-1:0] leaf_val[$];
  logic [LEN_W-1:0]  leaf_len[$];
  logic [SYM_W-1:0]  leaf_sym[$];
  logic [SYM_W-1:0]  prev_sym[$];   // symbols of the previous set, for removal by length 0

  always #5 clk = ~clk;

  huffman_prefix_decoder uut (.*);

  // results are sampled at the edge where they are taken
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      decoder.check_result(out_decoded_symbol, out_overflow_error);
  end

  // idle length: mostly none, a few short, rarely long
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // receiver: alternating runs and stalls, one long hold-off on request
  initial begin
    int left;
    bit stalling;
    left     = 0;
    stalling = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        n_holds++;
        stalling  = 1'b1;
        left      = HOLD_CYC - 1;
        out_stall <= 1'b1;
      end else if (left > 0) begin
        left--;
      end else if (stalling) begin
        // stretch without stalls now and then
        stalling  = 1'b0;
        left      = ($urandom_range(9) == 0) ? $urandom_range(300, 100) : $urandom_range(8, 1);
        out_stall <= 1'b0;
      end else begin
        stalling  = 1'b1;
        left      = idle_len();
        out_stall <= 1'b1;
      end
    end
  end

  // offer one request and wait for it to be taken
  task automatic send(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym, logic [CODE_W-1:0] val,
                      logic [LEN_W-1:0] len, logic cbit);
    int gap;
    gap = gapless ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_symbol      <= sym;
    in_code_value  <= val;
    in_code_length <= len;
    in_coded_bit   <= cbit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decoder.take_request(cmd, sym, val, len, cbit);
    if (cmd == CMD_LOAD) n_loads++;
    if (cmd == CMD_LOAD && int'(len) > LIMIT) n_rejected++;
    else n_sent++;
  endtask

  // unused fields always carry random values
  task automatic send_bit(logic cbit);
    send(CMD_DECODE, SYM_W'($urandom()), CODE_W'($urandom()), LEN_W'($urandom()), cbit);
  endtask

  task automatic send_end();
    send(CMD_END, SYM_W'($urandom()), CODE_W'($urandom()), LEN_W'($urandom()),
         1'($urandom_range(1)));
  endtask

  task automatic send_clear();
    send(CMD_CLEAR, SYM_W'($urandom()), CODE_W'($urandom()), LEN_W'($urandom()),
         1'($urandom_range(1)));
  endtask

  // stray: random bits above the code length, which the block must drop
  task automatic send_load(logic [SYM_W-1:0] sym, logic [CODE_W-1:0] code,
                           logic [LEN_W-1:0] len, bit stray);
    logic [31:0] v;
    v = 32'(code);
    if (stray) v = v | ($urandom() << len);
    send(CMD_LOAD, sym, v[CODE_W-1:0], len, 1'($urandom_range(1)));
  endtask

  // complete prefix code by splitting leaves; deep keeps splitting the newest pair
  function automatic void build_code(int n, bit deep);
    int pick;
    logic [CODE_W-1:0] v;
    logic [LEN_W-1:0]  l;
    leaf_val.delete();
    leaf_len.delete();
    leaf_val.push_back('0);
    leaf_len.push_back(LEN_W'(1));
    leaf_val.push_back(CODE_W'(1));
    leaf_len.push_back(LEN_W'(1));
    while (leaf_val.size() < n) begin
      if (deep) pick = leaf_val.size() - 1 - int'($urandom_range(1));
      else pick = $urandom_range(leaf_val.size() - 1);
      if (int'(leaf_len[pick]) >= LIMIT) continue;
      v = leaf_val[pick];
      l = leaf_len[pick];
      leaf_val.delete(pick);
      leaf_len.delete(pick);
      leaf_val.push_back(v << 1);
      leaf_len.push_back(l + 1'b1);
      leaf_val.push_back((v << 1) | CODE_W'(1));
      leaf_len.push_back(l + 1'b1);
    end
  endfunction

  // distinct random symbols for the leaves
  function automatic void assign_symbols();
    bit [SYMBOL_COUNT-1:0] taken;
    int s;
    taken = '0;
    leaf_sym.delete();
    foreach (leaf_val[i]) begin
      s = $urandom_range(SYMBOL_COUNT - 1);
      while (taken[s]) s = $urandom_range(SYMBOL_COUNT - 1);
      taken[s] = 1'b1;
      leaf_sym.push_back(SYM_W'(s));
    end
  endfunction

  // table setup then a stream of whole codewords with a few broken ones
  task automatic coded_episode(bit short_codes, bit squeeze);
    int n;
    int words;
    int idx;
    int skip;
    int stop;
    bit deep;
    deep = !short_codes && ($urandom_range(3) == 0);
    if (short_codes) n = $urandom_range(4, 2);
    else if (deep) n = LIMIT + 1;
    else n = $urandom_range(10, 2);

    // old set goes either by a full clear or by length-0 loads
    if (prev_sym.size() == 0 || $urandom_range(2) == 0) begin
      send_clear();
    end else begin
      foreach (prev_sym[i]) send_load(prev_sym[i], CODE_W'($urandom()), '0, 1'b0);
    end

    build_code(n, deep);
    assign_symbols();
    // leaving one leaf out lets the stream run into overflow
    skip = ($urandom_range(3) == 0) ? int'($urandom_range(n - 1)) : -1;
    foreach (leaf_val[i]) begin
      if (i != skip) send_load(leaf_sym[i], leaf_val[i], leaf_len[i], 1'($urandom_range(1)));
    end
    prev_sym = leaf_sym;
    if (skip >= 0) begin
      leaf_val.delete(skip);
      leaf_len.delete(skip);
      leaf_sym.delete(skip);
    end
    // second symbol on an existing code, the lower one must win
    if ($urandom_range(4) == 0) begin
      idx = $urandom_range(leaf_val.size() - 1);
      prev_sym.push_back(SYM_W'($urandom()));
      send_load(prev_sym[$], leaf_val[idx], leaf_len[idx], 1'b0);
    end
    // code longer than the limit, table must stay as it is
    if ($urandom_range(5) == 0)
      send_load(SYM_W'($urandom()), CODE_W'($urandom()),
                LEN_W'($urandom_range((1 << LEN_W) - 1, LIMIT + 1)), 1'b0);

    if (squeeze) hold_req = 1'b1;
    words = short_codes ? $urandom_range(60, 30) : $urandom_range(50, 10);
    repeat (words) begin
      idx  = $urandom_range(leaf_val.size() - 1);
      stop = 0;
      // stray bit knocks the stream out of step
      if ($urandom_range(29) == 0) send_bit(1'($urandom_range(1)));
      // partial codeword cut off by end of stream
      if (leaf_len[idx] > 1 && $urandom_range(19) == 0)
        stop = int'(leaf_len[idx]) - int'($urandom_range(int'(leaf_len[idx]) - 1, 1));
      for (int b = int'(leaf_len[idx]) - 1; b >= stop; b--) send_bit(leaf_val[idx][b]);
      if (stop > 0) send_end();
    end
    if ($urandom_range(1) == 0) send_end();
  endtask

  // random requests of every kind against whatever table is loaded
  task automatic noise_episode();
    int r;
    repeat ($urandom_range(80, 30)) begin
      r = $urandom_range(99);
      if (r < 70) send_bit(1'($urandom_range(1)));
      else if (r < 85) send_load(SYM_W'($urandom()), CODE_W'($urandom()), LEN_W'($urandom()), 1'b0);
      else if (r < 97) send_end();
      else send_clear();
    end
  endtask

  // extremes, duplicates, removal, rejected load, end of stream
  task automatic directed();
    send_clear();
    send_load('0, 16'hFFFE, LEN_W'(1), 1'b0);            // code 0, upper bits dropped
    send_load(SYM_W'(3), '0, LEN_W'(1), 1'b0);           // same code, symbol 0 still wins
    send_load(SYM_LAST, 16'hFFFF, LEN_W'(LIMIT), 1'b0);  // longest code, all ones
    send_load(SYM_W'(7), 16'h5555, '1, 1'b0);            // too long, ignored
    send_bit(1'b0);
    send_load('0, 16'hFFFF, '0, 1'b0);                   // remove symbol 0
    send_bit(1'b0);
    send_bit(1'b1);
    send_bit(1'b1);
    send_end();                                          // partial code dropped
    repeat (LIMIT) send_bit(1'b1);
  endtask

  initial begin
    int r;
    int ep;
    hpd_result_t want;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // block sweeps its lookup ram here with in_stall high, send waits it out
    directed();
    n_sent = 0;
    ep     = 0;
    while (n_sent < N_ITEMS) begin
      r       = $urandom_range(99);
      gapless = ($urandom_range(4) == 0);
      if (ep == 2) begin
        gapless = 1'b1;
        coded_episode(1'b1, 1'b1);
      end else if (r < 70) begin
        coded_episode(1'b0, 1'b0);
      end else if (r < 82) begin
        coded_episode(1'b1, 1'b0);
      end else begin
        noise_episode();
      end
      ep++;
    end
    in_valid <= 1'b0;

    for (int i = 0; i < WAIT_CYC && decoder.due_results.size() != 0; i++) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    while (decoder.due_results.size() != 0) begin
      want = decoder.due_results.pop_front();
      decoder.flag($sformatf("missing result, symbol %0d overflow %0b", want.sym, want.overflow));
    end

    $display("%0d random requests in %0d episodes, %0d loads (%0d too long), %0d long holds",
             n_sent, ep, n_loads, n_rejected, n_holds);
    $display("%0d decoded symbols and %0d overflow results checked, %0d mismatches",
             decoder.n_symbols, decoder.n_overflows, decoder.mismatches);
    if (decoder.mismatches == 0) begin
      $display("tb_huffman_prefix_decoder: clean");
    end else begin
      $display("tb_huffman_prefix_decoder: errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #30_000_000;
    $display("tb_huffman_prefix_decoder: errors");
    $finish;
  end

endmodule
